// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They sample on clk and are disabled
// while rst_n is low, so every user must have those two signals in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Widths, fixed-point constants and register indexes of the incremental
// PID motor speed core.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

  // Fraction bits of the gain registers and of the integrator.
  localparam int GAIN_FRAC_BITS = 16;

  // Field widths.
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 15;
  localparam int TARGET_W = 16;
  localparam int MEAS_W   = 15;
  localparam int LEVEL_W  = 16;
  localparam int ERR_W    = 17;
  localparam int ACC_W    = 48;

  // Datapath widths derived from the fields.
  localparam int ESUM_W  = ERR_W + 1;
  localparam int PPROD_W = GAIN_W + 1 + ERR_W;
  localparam int IPROD_W = GAIN_W + 1 + ESUM_W;
  localparam int SUM_W   = ACC_W + 2;

  // Port widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // Reset value of the level limit.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN     = 2'd0,
    CFG_KI_GAIN     = 2'd1,
    CFG_KD_GAIN     = 2'd2,
    CFG_LEVEL_LIMIT = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: rtl/incremental_pid_motor_speed_core.sv
// An accepted item is held in the input register and moves through the compute stage
// into the result register, which drives out_tvalid; a stalled result stream holds it.
// Throughput: one item per cycle while out_tready keeps the result register free; the
// controller state (level, last error, integrator, direction) is updated by the compute stage.
// Reset (rst_n low, synchronous): pipeline empty, controller state zero,
// gains zero and level limit at its maximum.
// ----------------------------------------------------------------------------
// incremental_pid_motor_speed_core
// Incremental PID speed controller for one motor channel: an input register,
// one pass of compute logic that updates the controller state, and a result
// register toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module incremental_pid_motor_speed_core
  import ipid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // target_speed[15:0], measured_speed[30:16]
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // drive_level[15:0], direction_negative[16]
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic signed [SUM_W-1:0] ROUND_ADJ =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [LEVEL_W-1:0] LVL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LVL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  // Configuration registers.
  logic [GAIN_W-1:0]  kp_gain_r;
  logic [GAIN_W-1:0]  ki_gain_r;
  logic [GAIN_W-1:0]  kd_gain_r;
  logic [LIMIT_W-1:0] level_limit_r;

  // Input register.
  logic                       in_valid_r;
  logic signed [TARGET_W-1:0] target_r;
  logic [MEAS_W-1:0]          meas_r;

  // Controller state.
  logic signed [LEVEL_W-1:0] level_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      dir_neg_r;

  // Result register.
  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] out_level_r;
  logic                      out_dir_r;

  // Compute signals.
  logic                       stage_fire;
  logic signed [ERR_W-1:0]    tgt_ext;
  logic signed [ERR_W-1:0]    meas_ext;
  logic signed [ERR_W-1:0]    err;
  logic signed [ESUM_W-1:0]   err_sum;
  logic signed [ESUM_W-1:0]   err_diff;
  logic signed [PPROD_W-1:0]  p_prod;
  logic signed [IPROD_W-1:0]  i_prod;
  logic signed [IPROD_W-1:0]  d_prod;
  logic signed [ACC_W:0]      acc_wide;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_adj;
  logic signed [SUM_W-1:0]    delta_full;
  logic signed [LEVEL_W-1:0]  delta;
  logic signed [LEVEL_W:0]    next_lvl;
  logic signed [LEVEL_W:0]    lim_pos;
  logic signed [LEVEL_W:0]    lim_neg;
  logic signed [LEVEL_W-1:0]  level_nxt;
  logic signed [ERR_W-1:0]    last_err_nxt;
  logic                       dir_neg_nxt;

  // Handshake: the compute stage moves when the result register is free.
  assign stage_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || stage_fire;

  // Error, signed by the remembered direction.
  always_comb begin
    tgt_ext  = ERR_W'(target_r);
    meas_ext = $signed({{(ERR_W-MEAS_W){1'b0}}, meas_r});
    err      = dir_neg_r ? (tgt_ext + meas_ext) : (tgt_ext - meas_ext);
    err_sum  = ESUM_W'(err) + ESUM_W'(last_err_r);
    err_diff = ESUM_W'(err) - ESUM_W'(last_err_r);
  end

  // Gain products, run in parallel.
  always_comb begin
    p_prod = $signed({1'b0, kp_gain_r}) * err;
    i_prod = $signed({1'b0, ki_gain_r}) * err_sum;
    d_prod = $signed({1'b0, kd_gain_r}) * err_diff;
  end

  // Integrator update with saturation to the accumulator range.
  always_comb begin
    acc_wide = (ACC_W+1)'(acc_r) + (ACC_W+1)'(i_prod);
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_nxt = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = acc_wide[ACC_W-1:0];
    end
  end

  // PID sum, truncated toward zero and saturated to the level width.
  always_comb begin
    sum        = SUM_W'(acc_nxt) + SUM_W'(p_prod) + SUM_W'(d_prod);
    sum_adj    = sum[SUM_W-1] ? (sum + ROUND_ADJ) : sum;
    delta_full = sum_adj >>> GAIN_FRAC_BITS;
    if ((&delta_full[SUM_W-1:LEVEL_W-1]) || !(|delta_full[SUM_W-1:LEVEL_W-1])) begin
      delta = delta_full[LEVEL_W-1:0];
    end else begin
      delta = delta_full[SUM_W-1] ? LVL_MIN : LVL_MAX;
    end
  end

  // Level update, direction tracking and clamp to the level limit.
  always_comb begin
    next_lvl = (LEVEL_W+1)'(level_r) + (LEVEL_W+1)'(delta);
    lim_pos  = $signed({{(LEVEL_W+1-LIMIT_W){1'b0}}, level_limit_r});
    lim_neg  = -lim_pos;
    if (target_r == '0) begin
      level_nxt    = '0;
      last_err_nxt = '0;
      dir_neg_nxt  = dir_neg_r;
    end else begin
      last_err_nxt = err;
      priority if (next_lvl > 0) begin
        dir_neg_nxt = 1'b0;
      end else if (next_lvl < 0) begin
        dir_neg_nxt = 1'b1;
      end else begin
        dir_neg_nxt = dir_neg_r;
      end
      priority if (next_lvl > lim_pos) begin
        level_nxt = lim_pos[LEVEL_W-1:0];
      end else if (next_lvl < lim_neg) begin
        level_nxt = lim_neg[LEVEL_W-1:0];
      end else begin
        level_nxt = next_lvl[LEVEL_W-1:0];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r     <= '0;
      ki_gain_r     <= '0;
      kd_gain_r     <= '0;
      level_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP_GAIN:     kp_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_KI_GAIN:     ki_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_KD_GAIN:     kd_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_LEVEL_LIMIT: level_limit_r <= cfg_wdata[LIMIT_W-1:0];
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      target_r <= $signed(in_tdata[TARGET_W-1:0]);
      meas_r   <= in_tdata[TARGET_W +: MEAS_W];
    end
  end

  // Controller state, updated once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      last_err_r <= '0;
      acc_r      <= '0;
      dir_neg_r  <= 1'b0;
    end else if (stage_fire) begin
      level_r    <= level_nxt;
      last_err_r <= last_err_nxt;
      acc_r      <= (target_r == '0) ? '0 : acc_nxt;
      dir_neg_r  <= dir_neg_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (stage_fire) begin
      out_level_r <= level_nxt;
      out_dir_r   <= dir_neg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-LEVEL_W-1){1'b0}}, out_dir_r, out_level_r};

  // A zero target always produces a zero drive level.
  `ASSERT_NXT(a_zero_target, stage_fire && (target_r == '0), out_valid_r && (out_level_r == '0))
  // A nonzero level always agrees with the remembered direction.
  `ASSERT_IMP(a_dir_sign, out_valid_r && (out_level_r != '0), out_dir_r == out_level_r[LEVEL_W-1])
  // The stored level matches the level just handed to the result register.
  `ASSERT_NXT(a_level_state, stage_fire, (level_r == out_level_r) && (dir_neg_r == out_dir_r))

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams speed samples through the incremental PID motor speed core and
// checks every drive level and direction against a local copy of the
// controller, over directed corner items and randomized control phases.
// ----------------------------------------------------------------------------

module testbench;
  import ipid_pkg::*;

  localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS = 160;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int IDLE_PERCENT = 17;

  // One control tick as it enters the core.
  typedef struct {
    logic signed [TARGET_W-1:0] target;
    logic [MEAS_W-1:0]          measured;
  } speed_sample_t;

  // One drive command as it leaves the core.
  typedef struct {
    logic signed [LEVEL_W-1:0] level;
    logic                      dir_neg;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;    // target_speed[15:0], measured_speed[30:16]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // drive_level[15:0], direction_negative[16]
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_KP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  speed_sample_t pending_samples[$];
  drive_cmd_t    expected_cmds[$];
  int error_count = 0;
  bit free_running = 1'b0;
  bit in_taken = 1'b0;
  int stall_requests = 0;
  int stalls_served = 0;
  int stall_left = 0;

  // Local copy of the controller registers and state.
  logic [GAIN_W-1:0]  ctl_kp = '0;
  logic [GAIN_W-1:0]  ctl_ki = '0;
  logic [GAIN_W-1:0]  ctl_kd = '0;
  logic [LIMIT_W-1:0] ctl_limit = LIMIT_RESET;
  longint ctl_level = 0;
  longint ctl_last_err = 0;
  longint ctl_integ = 0;
  logic ctl_dir_neg = 1'b0;

  incremental_pid_motor_speed_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the controller copy by one tick and returns the drive command.
  function automatic drive_cmd_t advance_controller(input speed_sample_t s);
    longint err;
    longint delta;
    longint nxt;
    longint lim;
    drive_cmd_t cmd;
    if (s.target == 0) begin
      ctl_level = 0;
      ctl_last_err = 0;
      ctl_integ = 0;
    end else begin
      // The measured magnitude is signed by the remembered direction.
      if (ctl_dir_neg) err = longint'(s.target) + longint'(s.measured);
      else err = longint'(s.target) - longint'(s.measured);
      ctl_integ = clip(ctl_integ + longint'(ctl_ki) * (err + ctl_last_err),
                       INTEG_MIN, INTEG_MAX);
      delta = (longint'(ctl_kp) * err + ctl_integ + longint'(ctl_kd) * (err - ctl_last_err))
              / (longint'(1) <<< GAIN_FRAC_BITS);
      delta = clip(delta, -32768, 32767);
      nxt = ctl_level + delta;
      // Direction follows the unclamped level; zero keeps it.
      if (nxt > 0) ctl_dir_neg = 1'b0;
      else if (nxt < 0) ctl_dir_neg = 1'b1;
      lim = longint'(ctl_limit);
      ctl_level = clip(nxt, -lim, lim);
      ctl_last_err = err;
    end
    cmd.level = ctl_level[LEVEL_W-1:0];
    cmd.dir_neg = ctl_dir_neg;
    return cmd;
  endfunction

  // Register writes, accepted items and results, all sampled at the rising edge.
  always @(posedge clk) begin
    speed_sample_t s;
    drive_cmd_t got;
    drive_cmd_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KP_GAIN:     ctl_kp = cfg_wdata;
          CFG_KI_GAIN:     ctl_ki = cfg_wdata;
          CFG_KD_GAIN:     ctl_kd = cfg_wdata;
          CFG_LEVEL_LIMIT: ctl_limit = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        s.target = in_tdata[TARGET_W-1:0];
        s.measured = in_tdata[TARGET_W +: MEAS_W];
        void'(pending_samples.pop_front());
        expected_cmds.push_back(advance_controller(s));
      end
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[LEVEL_W-1:0];
        got.dir_neg = out_tdata[LEVEL_W];
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: level %0d", got.level));
        end else begin
          want = expected_cmds.pop_front();
          if (got.level !== want.level)
            report_mismatch($sformatf("drive_level %0d, expected %0d", got.level, want.level));
          if (got.dir_neg !== want.dir_neg)
            report_mismatch($sformatf("direction_negative %0b, expected %0b",
                                      got.dir_neg, want.dir_neg));
        end
      end
    end
  end

  // Sender: offers the oldest pending item and holds it until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_samples.size() != 0 &&
          (free_running || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_DATA_W'({pending_samples[0].measured, pending_samples[0].target});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus long hold-offs on request.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_served < stall_requests) begin
      stalls_served <= stalls_served + 1;
      stall_left <= LONG_STALL_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= free_running || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic add_sample(input logic signed [TARGET_W-1:0] t, input logic [MEAS_W-1:0] m);
    speed_sample_t s;
    s.target = t;
    s.measured = m;
    pending_samples.push_back(s);
  endtask

  // Blocks until every item has been taken and every result has come back.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_cmds.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_controls(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KP_GAIN;
    cfg_wdata <= kp;
    @(negedge clk);
    cfg_index <= CFG_KI_GAIN;
    cfg_wdata <= ki;
    @(negedge clk);
    cfg_index <= CFG_KD_GAIN;
    cfg_wdata <= kd;
    @(negedge clk);
    cfg_index <= CFG_LEVEL_LIMIT;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Gains mostly in a useful span, sometimes at zero or full scale.
  function automatic logic [GAIN_W-1:0] pick_gain(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return GAIN_W'($urandom_range(span));
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return LIMIT_W'(1);
    if (roll < 4) return LIMIT_RESET;
    return LIMIT_W'($urandom_range(32767));
  endfunction

  // Stimulus and run control.
  initial begin
    int unsigned roll;
    int setpoint;
    int m;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero gains leave the level at zero and keep the direction.
    add_sample(16'sd32767, 15'd0);
    add_sample(-16'sd32768, 15'd32767);
    add_sample(16'sd0, 15'd0);
    add_sample(16'sd1, 15'd32767);
    add_sample(-16'sd1, 15'd1);
    wait_idle();

    // Full-scale gains: the level step saturates both ways and the direction flips.
    write_controls('1, '1, '1, LIMIT_RESET);
    add_sample(16'sd32767, 15'd0);
    add_sample(-16'sd32768, 15'd32767);
    add_sample(-16'sd32768, 15'd32767);
    add_sample(16'sd0, 15'd12345);
    add_sample(16'sd32767, 15'd32767);
    add_sample(-16'sd5, 15'd0);
    wait_idle();

    // Zero limit: the level stays at zero while the direction follows the sign.
    write_controls(24'h010000, '0, '0, '0);
    add_sample(16'sd100, 15'd0);
    add_sample(-16'sd200, 15'd0);
    add_sample(16'sd300, 15'd0);
    add_sample(16'sd0, 15'd0);
    wait_idle();

    // Unit limit with moderate gains.
    write_controls(24'h010000, 24'h000800, 24'h008000, LIMIT_W'(1));
    add_sample(16'sd50, 15'd10);
    add_sample(-16'sd50, 15'd10);
    add_sample(16'sd7, 15'd7);
    add_sample(16'sd0, 15'd0);
    add_sample(16'sd3000, 15'd2990);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_controls('0, '1, '0, LIMIT_RESET);
        1: write_controls(pick_gain(24'h030000), pick_gain(24'h004000),
                          pick_gain(24'h010000), '0);
        4: write_controls('1, '1, '1, pick_limit());
        default: write_controls(pick_gain(24'h030000), pick_gain(24'h004000),
                                pick_gain(24'h010000), pick_limit());
      endcase
      free_running = (phase == 2);
      if (phase == 3) stall_requests++;
      setpoint = 1000;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (phase == 5 && n == PHASE_TICKS / 2) wait_idle();
        roll = $urandom_range(99);
        if (phase == 0) begin
          // Steady positive error winds the integrator up to its bound.
          add_sample(16'sd32767, MEAS_W'($urandom_range(100)));
        end else if (roll < 6) begin
          add_sample(16'sd0, MEAS_W'($urandom));
        end else if (roll < 26) begin
          add_sample(TARGET_W'($urandom), MEAS_W'($urandom));
        end else begin
          // Tracking: the measured speed stays near the setpoint.
          if (n % 32 == 0) begin
            setpoint = $urandom_range(1, ($urandom_range(4) == 0) ? 32767 : 3000);
            if ($urandom_range(1) == 1) setpoint = -setpoint;
          end
          m = ((setpoint < 0) ? -setpoint : setpoint) + int'($urandom_range(128)) - 64;
          if (m < 0) m = 0;
          if (m > 32767) m = 32767;
          add_sample(TARGET_W'(setpoint), MEAS_W'(m));
        end
      end
      wait_idle();
    end
    free_running = 1'b0;

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("incremental_pid_motor_speed_core test passed");
    end else begin
      $display("incremental_pid_motor_speed_core test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("incremental_pid_motor_speed_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ipid_pkg.sv
rtl/incremental_pid_motor_speed_core.sv
dv/testbench.sv
